// File: rtl/scaled_virtual_timebase_unit_macros.svh
// ----------------------------------------------------------------------------
// scaled_virtual_timebase_unit_macros
// assertion helpers shared by the timebase unit
// ----------------------------------------------------------------------------
`ifndef SCALED_VIRTUAL_TIMEBASE_UNIT_MACROS_SVH
`define SCALED_VIRTUAL_TIMEBASE_UNIT_MACROS_SVH

// property that must hold at every edge out of reset
`define SVT_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define SVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication
`define SVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// File: rtl/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// widths, codes and control types of the scaled virtual timebase unit
// ----------------------------------------------------------------------------
package svt_pkg;

    // field widths
    localparam int DATA_W     = 64;
    localparam int FACTOR_W   = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = DATA_W + FACTOR_W;
    localparam int SEL_W      = $clog2(FACTOR_W);
    localparam int STEP_W     = $clog2(DATA_W);

    // largest positive counter value
    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};

    // scaling modes
    localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPEEDUP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLOWDOWN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 1'b1;

    // register reset values
    localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_NORMAL;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd1;

    // item operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // datapath commands
    localparam logic [3:0] DP_HOLD     = 4'd0;
    localparam logic [3:0] DP_CAPTURE  = 4'd1;
    localparam logic [3:0] DP_LOAD     = 4'd2;
    localparam logic [3:0] DP_DELTA    = 4'd3;
    localparam logic [3:0] DP_MUL_INIT = 4'd4;
    localparam logic [3:0] DP_MUL_STEP = 4'd5;
    localparam logic [3:0] DP_DIV_INIT = 4'd6;
    localparam logic [3:0] DP_DIV_STEP = 4'd7;
    localparam logic [3:0] DP_ACCUM    = 4'd8;

    // sequencer to datapath control
    typedef struct packed {
        logic [3:0]       op;
        logic [SEL_W-1:0] bit_sel;
    } t_dp_ctrl;

endpackage

// File: rtl/svt_in_if.sv
// ----------------------------------------------------------------------------
// svt_in_if
// input item channel: operation and real counter reading
// ----------------------------------------------------------------------------
interface svt_in_if;
    import svt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [DATA_W-1:0] real_count;

    modport source (output valid, output op, output real_count, input ready);
    modport sink   (input valid, input op, input real_count, output ready);
endinterface

// File: rtl/svt_out_if.sv
// ----------------------------------------------------------------------------
// svt_out_if
// result channel: virtual counter value
// ----------------------------------------------------------------------------
interface svt_out_if;
    import svt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] virtual_count;

    modport source (output valid, output virtual_count, input ready);
    modport sink   (input valid, input virtual_count, output ready);
endinterface

// File: rtl/svt_cfg_if.sv
// ----------------------------------------------------------------------------
// svt_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface svt_cfg_if;
    import svt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/svt_datapath.sv
// ----------------------------------------------------------------------------
// svt_datapath
// counter state and one shared 80-bit adder used for delta, shift-add
// multiply, restoring divide and the saturating accumulate
// ----------------------------------------------------------------------------
module svt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  svt_pkg::t_dp_ctrl             i_ctrl,
    input  logic [svt_pkg::FACTOR_W-1:0]  i_factor,
    input  logic [svt_pkg::DATA_W-1:0]    i_real_count,
    output logic [svt_pkg::DATA_W-1:0]    o_virtual_count
);
    import svt_pkg::*;

    logic [DATA_W-1:0]   r_in;
    logic [DATA_W-1:0]   r_last;
    logic [DATA_W-1:0]   r_virt;
    logic [DATA_W-1:0]   r_opnd;
    logic [ACC_W-1:0]    r_acc;
    logic [FACTOR_W:0]   r_rem;

    logic [ACC_W-1:0]    add_a;
    logic [ACC_W-1:0]    add_b;
    logic                add_cin;
    logic [ACC_W-1:0]    sum;
    logic                positive;
    logic [DATA_W-1:0]   cur;
    logic [FACTOR_W:0]   rem_shift;
    logic [DATA_W-2:0]   scaled;
    logic                sat;

    // operand select for the shared adder
    always_comb begin
        positive  = (r_in != '0) && !r_in[DATA_W-1];
        cur       = positive ? r_in : r_last;
        rem_shift = {r_rem[FACTOR_W-1:0], r_acc[DATA_W-1]};
        // clamp an oversized product to the largest positive value
        scaled    = (r_acc[ACC_W-1:DATA_W-1] != '0) ? MAX_POS[DATA_W-2:0]
                                                    : r_acc[DATA_W-2:0];
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (i_ctrl.op)
            DP_DELTA: begin
                add_a   = ACC_W'(cur);
                add_b   = ~ACC_W'(r_last);
                add_cin = 1'b1;
            end
            DP_MUL_STEP: begin
                add_a = {r_acc[ACC_W-2:0], 1'b0};
                add_b = i_factor[i_ctrl.bit_sel] ? ACC_W'(r_opnd) : '0;
            end
            DP_DIV_STEP: begin
                add_a   = ACC_W'(rem_shift);
                add_b   = ~ACC_W'(i_factor);
                add_cin = 1'b1;
            end
            DP_ACCUM: begin
                add_a = ACC_W'(r_virt);
                add_b = ACC_W'(scaled);
            end
            default: begin
            end
        endcase
        sum = add_a + add_b + ACC_W'(add_cin);
        // old value already at the top, or the sum ran past it
        sat = r_virt[DATA_W-1] || (&r_virt[DATA_W-2:0]) ||
              (sum[ACC_W-1:DATA_W-1] != '0);
    end

    // stored counter values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_virt <= '0;
        end else begin
            case (i_ctrl.op)
                DP_LOAD: begin
                    r_last <= r_in;
                    r_virt <= r_in;
                end
                DP_DELTA: begin
                    r_last <= cur;
                end
                DP_ACCUM: begin
                    r_virt <= sat ? MAX_POS : sum[DATA_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // working registers of the iterative unit
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            DP_CAPTURE: begin
                r_in <= i_real_count;
            end
            DP_DELTA: begin
                // a negative difference means the counter went back
                r_acc <= sum[ACC_W-1] ? '0 : ACC_W'(sum[DATA_W-1:0]);
            end
            DP_MUL_INIT: begin
                r_opnd <= r_acc[DATA_W-1:0];
                r_acc  <= '0;
            end
            DP_MUL_STEP: begin
                r_acc <= sum;
            end
            DP_DIV_INIT: begin
                r_rem <= '0;
            end
            DP_DIV_STEP: begin
                r_rem                <= sum[ACC_W-1] ? rem_shift : sum[FACTOR_W:0];
                r_acc[DATA_W-1:0]    <= {r_acc[DATA_W-2:0], ~sum[ACC_W-1]};
            end
            default: begin
            end
        endcase
    end

    assign o_virtual_count = r_virt;

endmodule

// File: rtl/svt_seq.sv
// ----------------------------------------------------------------------------
// svt_seq
// sequencer that steps the shared datapath through one item
// ----------------------------------------------------------------------------
module svt_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_op,
    input  logic [svt_pkg::MODE_W-1:0]  i_mode,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output svt_pkg::t_dp_ctrl           o_ctrl
);
    import svt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_DELTA = 4'd2;
    localparam logic [3:0] S_MINIT = 4'd3;
    localparam logic [3:0] S_MSTEP = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DSTEP = 4'd6;
    localparam logic [3:0] S_ACCUM = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STEP_W-1:0] r_cnt;
    logic [STEP_W-1:0] n_cnt;

    // next state and datapath command
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_ctrl.op      = DP_HOLD;
        // multiplier bits are taken from the top down
        o_ctrl.bit_sel = ~r_cnt[SEL_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.op = DP_CAPTURE;
                    n_state   = (i_in_op == OP_LOAD) ? S_LOAD : S_DELTA;
                end
            end
            S_LOAD: begin
                o_ctrl.op = DP_LOAD;
                n_state   = S_DONE;
            end
            S_DELTA: begin
                o_ctrl.op = DP_DELTA;
                n_cnt     = '0;
                case (i_mode)
                    MODE_SPEEDUP:  n_state = S_MINIT;
                    MODE_SLOWDOWN: n_state = S_DINIT;
                    default:       n_state = S_ACCUM;
                endcase
            end
            S_MINIT: begin
                o_ctrl.op = DP_MUL_INIT;
                n_state   = S_MSTEP;
            end
            S_MSTEP: begin
                o_ctrl.op = DP_MUL_STEP;
                n_cnt     = r_cnt + STEP_W'(1);
                if (r_cnt[SEL_W-1:0] == '1) begin
                    n_state = S_ACCUM;
                end
            end
            S_DINIT: begin
                o_ctrl.op = DP_DIV_INIT;
                n_state   = S_DSTEP;
            end
            S_DSTEP: begin
                o_ctrl.op = DP_DIV_STEP;
                n_cnt     = r_cnt + STEP_W'(1);
                if (r_cnt == '1) begin
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM: begin
                o_ctrl.op = DP_ACCUM;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

endmodule

// File: rtl/scaled_virtual_timebase_unit.sv
// ----------------------------------------------------------------------------
// scaled_virtual_timebase_unit
// virtual counter that follows a real counter with scaled elapsed time
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one beat per request: op 0 samples the real counter and
//   advances the virtual counter, op 1 loads both stored values. Each beat
//   gives exactly one o_result beat with the new virtual counter.
//   i_cfg writes mode (index 0) and factor (index 1); writes are always
//   taken and also affect an item in progress that has not yet read them.
// Steps from input beat to result valid, arithmetic on one 80-bit adder:
//   load: capture, load. Normal: capture, delta, accumulate. Speed-up adds
//   multiply init and one shift-add per factor bit; slow-down adds divide
//   init and one restoring divide step per delta bit, before accumulate.
// Throughput: one item at a time; i_item.ready is high only while idle, and
//   the unit returns to idle after each result beat.
// Reset: synchronous, clears both counters to zero, mode to normal and
//   factor to one.
// Stall: the result is held in the virtual counter register until
//   o_result.ready; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
`include "scaled_virtual_timebase_unit_macros.svh"

module scaled_virtual_timebase_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svt_cfg_if.sink     i_cfg,
    svt_in_if.sink      i_item,
    svt_out_if.source   o_result
);
    import svt_pkg::*;

    logic [MODE_W-1:0]   r_mode;
    logic [FACTOR_W-1:0] r_factor;
    logic [FACTOR_W-1:0] factor_eff;
    logic [DATA_W-1:0]   virt;
    t_dp_ctrl            dp_ctrl;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RESET;
            r_factor <= FACTOR_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MODE:   r_mode   <= i_cfg.data[MODE_W-1:0];
                CFG_FACTOR: r_factor <= i_cfg.data[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a zero factor acts as one
    assign factor_eff = (r_factor == '0) ? FACTOR_W'(1) : r_factor;

    // sequencer
    svt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_op     (i_item.op),
        .i_mode      (r_mode),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_ctrl      (dp_ctrl)
    );

    // shared arithmetic datapath
    svt_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (dp_ctrl),
        .i_factor        (factor_eff),
        .i_real_count    (i_item.real_count),
        .o_virtual_count (virt)
    );

    assign o_result.virtual_count = virt;

    // checks
    `SVT_ASSERT_ALWAYS(a_one_item, i_clk, i_rst_n, !(i_item.ready && o_result.valid), "input taken while result pending")
    `SVT_ASSERT_IMP(a_load_value, i_clk, i_rst_n, i_item.valid && i_item.ready && (i_item.op == OP_LOAD), ##2 (o_result.valid && (o_result.virtual_count == $past(i_item.real_count, 2))), "load result wrong")
    `SVT_ASSERT_NXT(a_back_idle, i_clk, i_rst_n, o_result.valid && o_result.ready, i_item.ready, "not idle after result beat")

endmodule
